@@ hw/rtl/per_class_box_nms_assert.svh @@
// Assertion macros used by the checker file of the box suppression block.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef PER_CLASS_BOX_NMS_ASSERT_SVH
`define PER_CLASS_BOX_NMS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PCBN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcbn assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PCBN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcbn assertion failed");

`endif

@@ hw/rtl/pcbn_pkg.sv @@
// Package of the per-class box suppression block: beat types, register codes,
// controller/datapath command and status structs. No dependencies.
package pcbn_pkg;

  localparam int MaxBoxesDef = 64;
  localparam int CfgIdxW     = 2;
  localparam logic [15:0] ScoreThrRst = 16'd32768;
  localparam logic [15:0] OvlThrRst   = 16'd32768;

  localparam logic [CfgIdxW-1:0] CFG_SCORE_THR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OVL_THR   = 2'd1;

  typedef struct packed {
    logic [15:0] in_center_x;
    logic [15:0] in_center_y;
    logic [15:0] in_width;
    logic [15:0] in_height;
    logic [15:0] in_score;
    logic [7:0]  in_class;
    logic        in_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_center_x;
    logic [15:0] out_center_y;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [15:0] out_score;
    logic [7:0]  out_class;
    logic        out_valid;
    logic        out_last;
  } out_item_t;

  typedef struct packed {
    logic load;       // take the candidate on the input
    logic scan_clr;   // rewind the scan index, drop the current best
    logic scan_inc;   // advance the scan index
    logic sel_take;   // scanned entry becomes the best
    logic rd_best;    // address the stores with the best index
    logic a_latch;    // hold the best box geometry, mark it done
    logic sup_mark;   // mark scanned entry done when the overlap test hits
    logic emit_push;  // release held result, hold the new one
    logic finish;     // release final result, clear frame state
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic scan_end;
    logic best_valid;
    logic j_better;
    logic j_skip;
  } sts_t;

endpackage

@@ hw/rtl/pcbn_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pcbn_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pcbn_ctrl.sv @@
// Sequencer of the box suppression block: load, select, suppress, emit.
// Depends on pcbn_pkg.
module pcbn_ctrl
  import pcbn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEL_INIT, ST_SEL_RD, ST_SEL_CMP, ST_A_RD, ST_A_LAT,
    ST_SUP_RD, ST_SUP_S1, ST_SUP_S2, ST_SUP_S3, ST_SUP_S4, ST_SUP_S5,
    ST_EMIT, ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start && !busy_q) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_last) begin
            state_d = ST_SEL_INIT;
            busy_d  = 1'b1;
          end
        end
      end
      ST_SEL_INIT: begin
        cmd_o.scan_clr = 1'b1;
        state_d = ST_SEL_RD;
      end
      ST_SEL_RD: begin
        if (sts_i.scan_end) begin
          state_d = sts_i.best_valid ? ST_A_RD : ST_FIN;
        end else begin
          state_d = ST_SEL_CMP;
        end
      end
      ST_SEL_CMP: begin
        cmd_o.sel_take = sts_i.j_better;
        cmd_o.scan_inc = 1'b1;
        state_d = ST_SEL_RD;
      end
      ST_A_RD: begin
        cmd_o.rd_best = 1'b1;
        state_d = ST_A_LAT;
      end
      ST_A_LAT: begin
        cmd_o.rd_best  = 1'b1;
        cmd_o.a_latch  = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d = ST_SUP_RD;
      end
      ST_SUP_RD: begin
        state_d = sts_i.scan_end ? ST_EMIT : ST_SUP_S1;
      end
      ST_SUP_S1: begin
        if (sts_i.j_skip) begin
          cmd_o.scan_inc = 1'b1;
          state_d = ST_SUP_RD;
        end else begin
          state_d = ST_SUP_S2;
        end
      end
      ST_SUP_S2: state_d = ST_SUP_S3;
      ST_SUP_S3: state_d = ST_SUP_S4;
      ST_SUP_S4: state_d = ST_SUP_S5;
      ST_SUP_S5: begin
        cmd_o.sup_mark = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d = ST_SUP_RD;
      end
      ST_EMIT: begin
        cmd_o.emit_push = 1'b1;
        state_d = ST_SEL_INIT;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

@@ hw/rtl/pcbn_dp.sv @@
// Datapath of the box suppression block: box stores, counters, best-box
// selection, staged overlap test and result registers. Depends on pcbn_pkg.
module pcbn_dp
  import pcbn_pkg::*;
#(
  parameter int MaxBoxes = MaxBoxesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_item_t           in_item_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               out_strobe_o,
  output out_item_t          out_item_o
);

  localparam int CntW = $clog2(MaxBoxes + 1);
  localparam int IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBoxes);

  logic [15:0]         score_thr_q, ovl_thr_q;
  logic [CntW-1:0]     stored_q, seen_q, j_q;
  logic [MaxBoxes-1:0] done_q;
  logic [IdxW-1:0]     best_q;
  logic [15:0]         best_score_q;
  logic [7:0]          best_class_q;
  logic                best_valid_q;
  logic [63:0]         a_geo_q;
  out_item_t           pend_q, out_q;
  logic                pend_valid_q, strobe_q;

  logic [63:0] rd_geo;
  logic [23:0] rd_sc;
  logic [IdxW-1:0] raddr, j_idx;
  logic        store_en;

  assign j_idx    = j_q[IdxW-1:0];
  assign raddr    = cmd_i.rd_best ? best_q : j_idx;
  assign store_en = cmd_i.load && (seen_q < MaxCnt) && (in_item_i.in_score > score_thr_q);

  pcbn_ram #(.Width(64), .Depth(MaxBoxes)) u_geo_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (stored_q[IdxW-1:0]),
    .wdata_i ({in_item_i.in_height, in_item_i.in_width,
               in_item_i.in_center_y, in_item_i.in_center_x}),
    .raddr_i (raddr),
    .rdata_o (rd_geo)
  );

  pcbn_ram #(.Width(24), .Depth(MaxBoxes)) u_sc_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (stored_q[IdxW-1:0]),
    .wdata_i ({in_item_i.in_score, in_item_i.in_class}),
    .raddr_i (raddr),
    .rdata_o (rd_sc)
  );

  // Status toward the sequencer
  logic j_done, rank_better;
  assign j_done      = done_q[j_idx];
  assign rank_better = (rd_sc[7:0] < best_class_q) ||
                       ((rd_sc[7:0] == best_class_q) && (rd_sc[23:8] > best_score_q));

  assign sts_o.in_last    = in_item_i.in_last;
  assign sts_o.scan_end   = (j_q == stored_q);
  assign sts_o.best_valid = best_valid_q;
  assign sts_o.j_better   = !j_done && (!best_valid_q || rank_better);
  assign sts_o.j_skip     = j_done || (rd_sc[7:0] != best_class_q);

  // Overlap test, stage 1: doubled edges, clipped extents, box areas
  logic signed [18:0] al, ar, at, ab, bl, br, bt, bb, el, er, et, eb, ex, ey;
  logic [17:0] dx, dy;

  always_comb begin
    al = $signed({2'b00, a_geo_q[15:0], 1'b0})  - $signed({3'b000, a_geo_q[47:32]});
    ar = $signed({2'b00, a_geo_q[15:0], 1'b0})  + $signed({3'b000, a_geo_q[47:32]});
    at = $signed({2'b00, a_geo_q[31:16], 1'b0}) - $signed({3'b000, a_geo_q[63:48]});
    ab = $signed({2'b00, a_geo_q[31:16], 1'b0}) + $signed({3'b000, a_geo_q[63:48]});
    bl = $signed({2'b00, rd_geo[15:0], 1'b0})   - $signed({3'b000, rd_geo[47:32]});
    br = $signed({2'b00, rd_geo[15:0], 1'b0})   + $signed({3'b000, rd_geo[47:32]});
    bt = $signed({2'b00, rd_geo[31:16], 1'b0})  - $signed({3'b000, rd_geo[63:48]});
    bb = $signed({2'b00, rd_geo[31:16], 1'b0})  + $signed({3'b000, rd_geo[63:48]});
    el = (al > bl) ? al : bl;
    er = (ar < br) ? ar : br;
    et = (at > bt) ? at : bt;
    eb = (ab < bb) ? ab : bb;
    ex = er - el;
    ey = eb - et;
    // disjoint boxes give zero intersection, which never suppresses
    if (ex[18] || ey[18]) begin
      dx = '0;
      dy = '0;
    end else begin
      dx = ex[17:0];
      dy = ey[17:0];
    end
  end

  logic [17:0] s1_dx_q, s1_dy_q;
  logic [31:0] s1_aa_q, s1_ab_q;
  logic [35:0] s2_inter_q, s3_inter_q, s4_inter_q;
  logic [32:0] s2_asum_q;
  logic [35:0] uni_full;
  logic [34:0] s3_uni_q;
  logic [50:0] s4_prod_q;
  logic        sup_hit;

  assign uni_full = {1'b0, s2_asum_q, 2'b00} - s2_inter_q;
  assign sup_hit  = {s4_inter_q, 16'h0000} > {1'b0, s4_prod_q};

  always_ff @(posedge clk_i) begin
    s1_dx_q    <= dx;
    s1_dy_q    <= dy;
    s1_aa_q    <= a_geo_q[47:32] * a_geo_q[63:48];
    s1_ab_q    <= rd_geo[47:32] * rd_geo[63:48];
    s2_inter_q <= s1_dx_q * s1_dy_q;
    s2_asum_q  <= {1'b0, s1_aa_q} + {1'b0, s1_ab_q};
    s3_inter_q <= s2_inter_q;
    s3_uni_q   <= uni_full[34:0];
    s4_inter_q <= s3_inter_q;
    s4_prod_q  <= ovl_thr_q * s3_uni_q;
  end

  // Final beat of a frame: the held box, or an empty result, tagged last
  out_item_t fin_item;
  always_comb begin
    fin_item          = pend_valid_q ? pend_q : '0;
    fin_item.out_last = 1'b1;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_take) begin
      best_q       <= j_idx;
      best_score_q <= rd_sc[23:8];
      best_class_q <= rd_sc[7:0];
    end
    if (cmd_i.a_latch) begin
      a_geo_q <= rd_geo;
    end
    if (cmd_i.emit_push) begin
      out_q  <= pend_q;
      pend_q <= '{out_center_x: a_geo_q[15:0], out_center_y: a_geo_q[31:16],
                  out_width: a_geo_q[47:32], out_height: a_geo_q[63:48],
                  out_score: best_score_q, out_class: best_class_q,
                  out_valid: 1'b1, out_last: 1'b0};
    end
    if (cmd_i.finish) begin
      out_q <= fin_item;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q  <= ScoreThrRst;
      ovl_thr_q    <= OvlThrRst;
      stored_q     <= '0;
      seen_q       <= '0;
      j_q          <= '0;
      done_q       <= '0;
      best_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      strobe_q <= cmd_i.finish || (cmd_i.emit_push && pend_valid_q);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SCORE_THR: score_thr_q <= cfg_data_i;
          CFG_OVL_THR:   ovl_thr_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && (seen_q < MaxCnt)) begin
        seen_q <= seen_q + 1'b1;
      end
      if (store_en) begin
        stored_q <= stored_q + 1'b1;
      end
      if (cmd_i.scan_clr) begin
        j_q          <= '0;
        best_valid_q <= 1'b0;
      end else if (cmd_i.scan_inc) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.sel_take) begin
        best_valid_q <= 1'b1;
      end
      if (cmd_i.a_latch) begin
        done_q[best_q] <= 1'b1;
      end
      if (cmd_i.sup_mark && sup_hit) begin
        done_q[j_idx] <= 1'b1;
      end
      if (cmd_i.emit_push) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
        stored_q     <= '0;
        seen_q       <= '0;
        done_q       <= '0;
      end
    end
  end

  assign out_strobe_o = strobe_q;
  assign out_item_o   = out_q;

endmodule

@@ hw/rtl/per_class_box_nms.sv @@
// Per-class greedy box suppression: candidates load at one beat per cycle while
// busy is low; the beat marked last raises busy. Each kept box then takes a
// selection scan and a suppression scan of the stores (overlap test only for open
// same-class entries); a closing scan ends the frame, paced by the single read port.
// Results trail by one kept-box pass, one per strobe; the receiver cannot stall.
// Reset is async, low: thresholds go to 0.5, frame state clears, stores do not.
module per_class_box_nms
  import pcbn_pkg::*;
#(
  parameter int MaxBoxes = MaxBoxesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item_i,
  output logic               out_strobe_o,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Registers are to be written only between frames; the block does not enforce this, so take every config beat.
  assign cfg_ready_o = 1'b1;

  // Sequencer: walks load, best-box selection, suppression and emit.
  pcbn_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: stores, scan index, done flags, staged IoU test, result hold.
  pcbn_dp #(.MaxBoxes(MaxBoxes)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_item_i    (in_item_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_strobe_o (out_strobe_o),
    .out_item_o   (out_item_o)
  );

endmodule

@@ hw/rtl/pcbn_chk.sv @@
// Port-level checker for per_class_box_nms, bound to the top level.
// Depends on pcbn_pkg and per_class_box_nms_assert.svh.
`include "per_class_box_nms_assert.svh"
module pcbn_chk
  import pcbn_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item_i,
  input logic      out_strobe_o,
  input out_item_t out_item_o
);

  `PCBN_ASSERT_IMP(a_empty_is_last, out_strobe_o && !out_item_o.out_valid, out_item_o.out_last)
  `PCBN_ASSERT_NXT(a_last_goes_busy, start && !busy && in_item_i.in_last, busy)
  `PCBN_ASSERT_IMP(a_mid_result_busy, out_strobe_o && !out_item_o.out_last, busy)
  `PCBN_ASSERT_IMP(a_final_result_idle, out_strobe_o && out_item_o.out_last, !busy)

endmodule

bind per_class_box_nms pcbn_chk u_chk (.*);
